// ----- rtl/ckb_pkg.sv -----
// Shared constants, codes and types of the canonical k-mer bucketer.
package ckb_pkg;

  localparam int MAX_EDGE_CHARS = 32;
  localparam int PREFIX_CHARS   = 8;

  localparam int WIN_W   = 2 * MAX_EDGE_CHARS;
  localparam int KEY_W   = 2 * PREFIX_CHARS;
  localparam int ALIGN_W = (WIN_W > KEY_W) ? WIN_W : KEY_W;
  localparam int N_W     = $clog2(MAX_EDGE_CHARS + 1);

  localparam int HIST_DEPTH = 1 << KEY_W;
  localparam int COUNT_W    = 32;
  localparam int BIR_W      = 32;
  localparam int RBASE_W    = 39;
  localparam int OFFS_W     = 41;
  localparam int SUM_W      = OFFS_W - 1;
  localparam int BKEY_W     = 16;
  localparam int K_W        = 5;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_COUNT = 1'b1
  } op_t;

  typedef enum logic {
    KIND_OFFSET = 1'b0,
    KIND_COUNT  = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_K    = 2'd0,
    CFG_LOW  = 2'd1,
    CFG_HIGH = 2'd2
  } cfg_idx_t;

  // Canonical edge of the window held in the rolling registers
  typedef struct packed {
    logic              closed;
    logic [KEY_W-1:0]  key;
    logic              strand;
    logic [OFFS_W-1:0] offs;
  } canon_t;

  typedef struct packed {
    kind_t              kind;
    logic [BKEY_W-1:0]  key;
    logic               strand;
    logic [OFFS_W-1:0]  offs;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

// ----- rtl/ckb_if.sv -----
// Valid/ready channel interfaces for bases in and results out.
interface ckb_base_if import ckb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               op;
  logic [1:0]         base_code;
  logic               first_of_read;
  logic [RBASE_W-1:0] read_base_offset;
  logic [BKEY_W-1:0]  bucket_index;

  modport source (output valid, op, base_code, first_of_read, read_base_offset,
                  bucket_index, input ready);
  modport sink (input valid, op, base_code, first_of_read, read_base_offset,
                bucket_index, output ready);
endinterface

interface ckb_result_if import ckb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [BKEY_W-1:0]  bucket_key;
  logic               strand;
  logic [OFFS_W-1:0]  encoded_offset;
  logic [COUNT_W-1:0] bucket_count;

  modport source (output valid, result_kind, bucket_key, strand, encoded_offset,
                  bucket_count, input ready);
  modport sink (input valid, result_kind, bucket_key, strand, encoded_offset,
                bucket_count, output ready);
endinterface

// ----- rtl/ckb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ckb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write of the same address returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ckb_window.sv -----
// Rolling forward/reverse-complement windows and canonical edge selection.
module ckb_window import ckb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [1:0]         base,
  input  logic               first,
  input  logic [RBASE_W-1:0] rbase,
  input  logic [N_W-1:0]     n,
  output canon_t             canon_info
);

  logic [WIN_W-1:0]   fwd, rev;
  logic [BIR_W-1:0]   bir;
  logic [RBASE_W-1:0] crb;

  logic [WIN_W-1:0]   mask;
  logic [WIN_W-1:0]   fwd_base, rev_base, fwd_next, rev_next;
  logic [BIR_W-1:0]   bir_base, bir_next;
  logic [RBASE_W-1:0] crb_next;
  logic [1:0]         comp;

  logic [BIR_W-1:0]   start;
  logic [WIN_W-1:0]   canon;
  logic [ALIGN_W-1:0] aligned;
  logic [SUM_W-1:0]   sum;
  logic               strand;

  always_comb begin
    mask     = {WIN_W{1'b1}} >> (WIN_W - 2 * int'(n));
    fwd_base = first ? '0 : fwd;
    rev_base = first ? '0 : rev;
    bir_base = first ? '0 : bir;
    crb_next = first ? rbase : crb;
    comp     = 2'd3 - base;
    fwd_next = ((fwd_base << 2) | WIN_W'(base)) & mask;
    rev_next = (((rev_base & mask) >> 2) | (WIN_W'(comp) << (2 * int'(n) - 2))) & mask;
    bir_next = (bir_base == '1) ? bir_base : bir_base + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= '0;
      rev <= '0;
      bir <= '0;
      crb <= '0;
    end else if (push) begin
      fwd <= fwd_next;
      rev <= rev_next;
      bir <= bir_next;
      crb <= crb_next;
    end
  end

  // evaluated in the cycle after the push, on the updated registers
  always_comb begin
    start   = bir - BIR_W'(n);
    strand  = rev < fwd;
    canon   = strand ? rev : fwd;
    aligned = ALIGN_W'(canon) << (ALIGN_W - 2 * int'(n));
    sum     = SUM_W'(crb) + SUM_W'(start);
    canon_info.closed = bir >= BIR_W'(n);
    canon_info.key    = aligned[ALIGN_W-1 -: KEY_W];
    canon_info.strand = strand;
    canon_info.offs   = {sum, strand};
  end

endmodule

// ----- rtl/ckb_skid_fifo.sv -----
// Small result queue that decouples the pipeline from the result channel.
module ckb_skid_fifo import ckb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  output logic [FIFO_CNT_W-1:0] count,
  ckb_result_if.source          results
);

  result_t               slot [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic                  pop;
  result_t               head;

  assign pop  = results.valid && results.ready;
  assign head = slot[rd_ptr];

  assign results.valid          = count != '0;
  assign results.result_kind    = head.kind;
  assign results.bucket_key     = head.key;
  assign results.strand         = head.strand;
  assign results.encoded_offset = head.offs;
  assign results.bucket_count   = head.count;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // upstream credit check keeps push away from a full queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
  end

endmodule

// ----- rtl/canonical_kmer_bucketer_unit.sv -----
// Top level of the canonical k-mer bucketer: config, histogram pipeline, result queue.
//
//   channel   dir  transfer moves
//   bases     in   op, base_code, first_of_read, read_base_offset, bucket_index
//   results   out  result_kind, bucket_key, strand, encoded_offset, bucket_count
//   cfg_*     in   cfg_we, cfg_index, cfg_data (write only)
//
// One item per cycle while bases.ready is high. Results enter the queue from stage 2;
// the histogram is read-modify-write on a registered-read RAM with a write-to-read bypass.
// After reset a clearing pass writes zero to all 65536 histogram entries, one per cycle,
// and bases.ready stays low until the pass is done.
// Ready drops once queued results plus items in the two pipeline stages reach four.
module canonical_kmer_bucketer_unit import ckb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ckb_base_if.sink             bases,
  ckb_result_if.source         results
);

  logic [K_W-1:0]    k;
  logic [BKEY_W-1:0] key_low, key_high;

  logic [K_W:0]   n_full;
  logic [N_W-1:0] n;

  logic accept, push;

  logic              s1_v, s1_count;
  logic [BKEY_W-1:0] s1_bidx;
  canon_t            canon_info;

  logic              s2_v, s2_count, s2_inc, s2_strand;
  logic [BKEY_W-1:0] s2_key;
  logic [OFFS_W-1:0] s2_offs;
  logic [KEY_W-1:0]  s2_addr;

  logic               clearing;
  logic [KEY_W-1:0]   clr_addr;

  logic               ram_we;
  logic [KEY_W-1:0]   ram_waddr, ram_raddr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;

  logic               wr_v_d;
  logic [KEY_W-1:0]   wr_addr_d;
  logic [COUNT_W-1:0] wr_data_d;

  logic [COUNT_W-1:0] cur, inc_val;
  logic               in_range;
  logic               res_push;
  result_t            res_data;

  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   occ;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= K_W'(31);
      key_low  <= '0;
      key_high <= '1;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_K:    k        <= cfg_data[K_W-1:0];
        CFG_LOW:  key_low  <= cfg_data[BKEY_W-1:0];
        CFG_HIGH: key_high <= cfg_data[BKEY_W-1:0];
        default:  ;
      endcase
    end
  end

  assign n_full = {1'b0, k} + 1'b1;
  assign n      = (n_full > (K_W + 1)'(MAX_EDGE_CHARS)) ? N_W'(MAX_EDGE_CHARS)
                                                         : N_W'(n_full);

  // input handshake with credit for queue plus in-flight stages
  assign occ          = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(s1_v)
                        + (FIFO_CNT_W + 1)'(s2_v);
  assign bases.ready  = !clearing && (occ < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign accept       = bases.valid && bases.ready;
  assign push         = accept && (bases.op == OP_PUSH);

  ckb_window u_window (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .base       (bases.base_code),
    .first      (bases.first_of_read),
    .rbase      (bases.read_base_offset),
    .n          (n),
    .canon_info (canon_info)
  );

  // stage 1: window registers updated, canonical key or count bucket index drives the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_count <= bases.op == OP_COUNT;
    s1_bidx  <= bases.bucket_index;
  end

  assign ram_raddr = s1_count ? s1_bidx[KEY_W-1:0] : canon_info.key;

  // stage 2: count returns from RAM, increment and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s2_count  <= s1_count;
    s2_inc    <= !s1_count && canon_info.closed;
    s2_key    <= s1_count ? s1_bidx : BKEY_W'(canon_info.key);
    s2_strand <= canon_info.strand;
    s2_offs   <= canon_info.offs;
  end

  assign s2_addr = s2_key[KEY_W-1:0];

  // bypass the write made in the cycle this read was issued
  assign cur     = (wr_v_d && wr_addr_d == s2_addr) ? wr_data_d : ram_rdata;
  assign inc_val = (cur == '1) ? cur : cur + 1'b1;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s2_v && s2_inc;
      ram_waddr = s2_addr;
      ram_wdata = inc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_v_d <= 1'b0;
    end else begin
      wr_v_d <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_d <= ram_waddr;
    wr_data_d <= ram_wdata;
  end

  ckb_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_range = (s2_key >= key_low) && (s2_key <= key_high);
  assign res_push = s2_v && (s2_count || (s2_inc && in_range));

  always_comb begin
    if (s2_count) begin
      res_data.kind   = KIND_COUNT;
      res_data.key    = s2_key;
      res_data.strand = 1'b0;
      res_data.offs   = '0;
      res_data.count  = cur;
    end else begin
      res_data.kind   = KIND_OFFSET;
      res_data.key    = s2_key;
      res_data.strand = s2_strand;
      res_data.offs   = s2_offs;
      res_data.count  = '0;
    end
  end

  ckb_skid_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .count     (fifo_count),
    .results   (results)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
    else $error("queue credit exceeded");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_v && !s2_v))
    else $error("pipeline active during histogram clear");

  a_count_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && bases.op == OP_COUNT) |-> ##2 res_push)
    else $error("count request gave no answer");

endmodule
